/* sv/plt_pkg.sv */
// Shared types and codes for the positional list table.
package plt_pkg;

  // Operation codes
  localparam logic [2:0] OP_APPEND = 3'd0;
  localparam logic [2:0] OP_INSERT = 3'd1;
  localparam logic [2:0] OP_DELETE = 3'd2;
  localparam logic [2:0] OP_READ   = 3'd3;
  localparam logic [2:0] OP_TAKE   = 3'd4;

  // Status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_NOKEY = 2'd3;

  typedef struct packed {
    logic [15:0] handle;
    logic [31:0] entry_key;
  } entry_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [5:0]  position;
    logic [15:0] entry_handle;
    logic [31:0] entry_key;
  } cmd_t;

  typedef struct packed {
    logic [1:0] status;
    entry_t     found;
    logic [6:0] entry_count;
    logic       is_empty;
  } rsp_t;

endpackage

/* sv/plt_ifs.sv */
// Valid/ready channel interfaces for the list table's command and result sides.
interface plt_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [5:0]  position;
  logic [15:0] entry_handle;
  logic [31:0] entry_key;

  modport source(output valid, output operation, output position,
                 output entry_handle, output entry_key, input ready);
  modport sink(input valid, input operation, input position,
               input entry_handle, input entry_key, output ready);
endinterface

interface plt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] found_handle;
  logic [31:0] found_start_time;
  logic [6:0]  entry_count;
  logic        is_empty;

  modport source(output valid, output status, output found_handle,
                 output found_start_time, output entry_count, output is_empty,
                 input ready);
  modport sink(input valid, input status, input found_handle,
               input found_start_time, input entry_count, input is_empty,
               output ready);
endinterface

/* sv/plt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module plt_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* sv/plt_ctrl.sv */
// Sequencer: decodes one command, then, where the command needs it, scans or shifts the store one entry per cycle.
module plt_ctrl #(
  parameter int CAPACITY = 64,
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  plt_pkg::cmd_t     cmd,
  output logic              idle,
  output logic              rsp_valid,
  input  logic              rsp_ack,
  output plt_pkg::rsp_t     rsp,
  output logic              ram_we,
  output logic [AW-1:0]     ram_waddr,
  output plt_pkg::entry_t   ram_wdata,
  output logic [AW-1:0]     ram_raddr,
  input  plt_pkg::entry_t   ram_rdata
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > 6) ? CW : 6;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_RDWAIT = 7'b0000100,
    S_SCAN   = 7'b0001000,
    S_SHIFT  = 7'b0010000,
    S_INSWR  = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t          state_r, state_nxt;
  plt_pkg::cmd_t   cmd_r, cmd_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   end_r, end_nxt;
  logic [AW-1:0]   cmp_ptr_r, cmp_ptr_nxt;
  logic            rd_more_r, rd_more_nxt;
  logic            pend_r, pend_nxt;
  logic            up_r, up_nxt;
  logic [1:0]      status_r, status_nxt;
  plt_pkg::entry_t found_r, found_nxt;

  logic [XW-1:0]   cnt_x, pos_x, at_x;
  logic [AW-1:0]   cnt_m1;
  logic            key_hit;
  logic            close_last;

  assign cnt_x      = XW'(count_r);
  assign pos_x      = XW'(cmd_r.position);
  assign at_x       = (cmd_r.operation == plt_pkg::OP_APPEND) ? cnt_x : pos_x;
  assign cnt_m1     = AW'(count_r - 1'b1);
  assign key_hit    = (ram_rdata.entry_key == cmd_r.entry_key);
  assign close_last = (cmp_ptr_r == cnt_m1);

  assign idle      = (state_r == S_IDLE);
  assign rsp_valid = (state_r == S_DONE);

  always_comb begin
    rsp.status      = status_r;
    rsp.found       = found_r;
    rsp.entry_count = 7'(count_r);
    rsp.is_empty    = (count_r == '0);
  end

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    count_nxt   = count_r;
    rd_ptr_nxt  = rd_ptr_r;
    wr_ptr_nxt  = wr_ptr_r;
    end_nxt     = end_r;
    cmp_ptr_nxt = cmp_ptr_r;
    rd_more_nxt = rd_more_r;
    pend_nxt    = pend_r;
    up_nxt      = up_r;
    status_nxt  = status_r;
    found_nxt   = found_r;
    ram_we      = 1'b0;
    ram_waddr   = wr_ptr_r;
    ram_wdata   = ram_rdata;
    ram_raddr   = rd_ptr_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt    = cmd;
          found_nxt  = '0;
          status_nxt = plt_pkg::ST_DONE;
          state_nxt  = S_DECODE;
        end
      end

      S_DECODE: begin
        case (cmd_r.operation)
          plt_pkg::OP_APPEND, plt_pkg::OP_INSERT: begin
            if (count_r == CAP_C) begin
              status_nxt = plt_pkg::ST_FULL;
              state_nxt  = S_DONE;
            end else if (at_x > cnt_x) begin
              status_nxt = plt_pkg::ST_RANGE;
              state_nxt  = S_DONE;
            end else if (at_x == cnt_x) begin
              // tail slot: write in place, nothing to move
              ram_we              = 1'b1;
              ram_waddr           = AW'(at_x);
              ram_wdata.handle    = cmd_r.entry_handle;
              ram_wdata.entry_key = cmd_r.entry_key;
              count_nxt           = count_r + 1'b1;
              state_nxt           = S_DONE;
            end else begin
              rd_ptr_nxt  = cnt_m1;
              wr_ptr_nxt  = AW'(count_r);
              end_nxt     = AW'(at_x);
              rd_more_nxt = 1'b1;
              pend_nxt    = 1'b0;
              up_nxt      = 1'b1;
              state_nxt   = S_SHIFT;
            end
          end
          plt_pkg::OP_DELETE, plt_pkg::OP_READ: begin
            if (pos_x >= cnt_x) begin
              status_nxt = plt_pkg::ST_RANGE;
              state_nxt  = S_DONE;
            end else begin
              ram_raddr   = AW'(pos_x);
              cmp_ptr_nxt = AW'(pos_x);
              state_nxt   = S_RDWAIT;
            end
          end
          plt_pkg::OP_TAKE: begin
            if (count_r == '0) begin
              status_nxt = plt_pkg::ST_NOKEY;
              state_nxt  = S_DONE;
            end else begin
              rd_ptr_nxt  = '0;
              end_nxt     = cnt_m1;
              rd_more_nxt = 1'b1;
              pend_nxt    = 1'b0;
              state_nxt   = S_SCAN;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      S_RDWAIT: begin
        found_nxt = ram_rdata;
        if (cmd_r.operation == plt_pkg::OP_READ) begin
          state_nxt = S_DONE;
        end else if (close_last) begin
          count_nxt = count_r - 1'b1;
          state_nxt = S_DONE;
        end else begin
          rd_ptr_nxt  = AW'(cmp_ptr_r + 1'b1);
          wr_ptr_nxt  = cmp_ptr_r;
          end_nxt     = cnt_m1;
          rd_more_nxt = 1'b1;
          pend_nxt    = 1'b0;
          up_nxt      = 1'b0;
          state_nxt   = S_SHIFT;
        end
      end

      S_SCAN: begin
        if (pend_r && key_hit) begin
          found_nxt = ram_rdata;
          pend_nxt  = 1'b0;
          if (close_last) begin
            count_nxt = count_r - 1'b1;
            state_nxt = S_DONE;
          end else begin
            rd_ptr_nxt  = AW'(cmp_ptr_r + 1'b1);
            wr_ptr_nxt  = cmp_ptr_r;
            end_nxt     = cnt_m1;
            rd_more_nxt = 1'b1;
            up_nxt      = 1'b0;
            state_nxt   = S_SHIFT;
          end
        end else if (!rd_more_r) begin
          pend_nxt   = 1'b0;
          status_nxt = plt_pkg::ST_NOKEY;
          state_nxt  = S_DONE;
        end else begin
          ram_raddr   = rd_ptr_r;
          cmp_ptr_nxt = rd_ptr_r;
          pend_nxt    = 1'b1;
          if (rd_ptr_r == end_r) begin
            rd_more_nxt = 1'b0;
          end else begin
            rd_ptr_nxt = rd_ptr_r + 1'b1;
          end
        end
      end

      S_SHIFT: begin
        // read one entry ahead, write it to its neighbor in the next cycle
        if (pend_r) begin
          ram_we     = 1'b1;
          ram_waddr  = wr_ptr_r;
          ram_wdata  = ram_rdata;
          wr_ptr_nxt = up_r ? (wr_ptr_r - 1'b1) : (wr_ptr_r + 1'b1);
        end
        if (rd_more_r) begin
          ram_raddr = rd_ptr_r;
          pend_nxt  = 1'b1;
          if (rd_ptr_r == end_r) begin
            rd_more_nxt = 1'b0;
          end else begin
            rd_ptr_nxt = up_r ? (rd_ptr_r - 1'b1) : (rd_ptr_r + 1'b1);
          end
        end else begin
          pend_nxt = 1'b0;
          if (up_r) begin
            state_nxt = S_INSWR;
          end else begin
            count_nxt = count_r - 1'b1;
            state_nxt = S_DONE;
          end
        end
      end

      S_INSWR: begin
        ram_we              = 1'b1;
        ram_waddr           = end_r;
        ram_wdata.handle    = cmd_r.entry_handle;
        ram_wdata.entry_key = cmd_r.entry_key;
        count_nxt           = count_r + 1'b1;
        state_nxt           = S_DONE;
      end

      S_DONE: begin
        if (rsp_ack) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      rd_more_r <= 1'b0;
      pend_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      rd_more_r <= rd_more_nxt;
      pend_r    <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    rd_ptr_r  <= rd_ptr_nxt;
    wr_ptr_r  <= wr_ptr_nxt;
    end_r     <= end_nxt;
    cmp_ptr_r <= cmp_ptr_nxt;
    up_r      <= up_nxt;
    status_r  <= status_nxt;
    found_r   <= found_nxt;
  end

endmodule

/* sv/positional_list_table.sv */
// Top level of the positional list table: channels, store and sequencer.
//
// Usage:
//  - in_ch carries one command per transfer: operation, position, entry_handle
//    and entry_key. It transfers when valid and ready are both high.
//  - out_ch returns exactly one result per command: status, found_handle,
//    found_start_time, entry_count and is_empty, in command order.
//  - Append, out-of-range, full and ignored commands finish at decode; read
//    and delete fetch the entry at the position; insert and delete shift
//    the entries behind the position; take by key compares entries from
//    the head and shifts the entries behind the first match. The single
//    read port of the store sets the pace: one entry moved or compared per
//    cycle.
//  - One command is in work at a time; in_ch.ready is low from the transfer
//    until the result moves into the output register, so no new command is
//    taken while the last one is still in work.
//  - The output register decouples the sides: the next command is accepted
//    while a finished result waits on a stalled out_ch. A second result then
//    holds in the sequencer until the register frees up.
//  - Reset (rst_n low at a clock edge) empties the list. The store has no
//    clearing pass; only entries below the count are ever read.
module positional_list_table #(
  parameter int CAPACITY = 64
) (
  input logic        clk,
  input logic        rst_n,
  plt_in_if.sink     in_ch,
  plt_out_if.source  out_ch
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  plt_pkg::cmd_t   cmd;
  plt_pkg::rsp_t   rsp;
  plt_pkg::rsp_t   out_r;
  logic            out_valid_r, out_valid_nxt;
  logic            eng_idle;
  logic            rsp_valid;
  logic            rsp_ack;
  logic            start;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [AW-1:0]   ram_raddr;
  plt_pkg::entry_t ram_wdata;
  plt_pkg::entry_t ram_rdata;

  // command side: ready only while the sequencer waits for work
  assign in_ch.ready = eng_idle;
  assign start       = in_ch.valid && eng_idle;

  always_comb begin
    cmd.operation    = in_ch.operation;
    cmd.position     = in_ch.position;
    cmd.entry_handle = in_ch.entry_handle;
    cmd.entry_key    = in_ch.entry_key;
  end

  // result moves into the output register when it is empty or draining
  assign rsp_ack = rsp_valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (rsp_ack) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_ack) begin
      out_r <= rsp;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.status           = out_r.status;
  assign out_ch.found_handle     = out_r.found.handle;
  assign out_ch.found_start_time = out_r.found.entry_key;
  assign out_ch.entry_count      = out_r.entry_count;
  assign out_ch.is_empty         = out_r.is_empty;

  plt_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .cmd       (cmd),
    .idle      (eng_idle),
    .rsp_valid (rsp_valid),
    .rsp_ack   (rsp_ack),
    .rsp       (rsp),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // entry store: handle and key side by side in one word
  plt_ram #(
    .WIDTH ($bits(plt_pkg::entry_t)),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

/* sv/plt_chk.sv */
// Port-level checks for the positional list table, bound to the top level.
module plt_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [15:0] found_handle,
  input logic [31:0] found_start_time,
  input logic [6:0]  entry_count,
  input logic        is_empty
);

  // one command in work at a time
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("command accepted while a command was in work");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (is_empty == (entry_count == 7'd0)))
    else $error("empty flag disagrees with entry count");

  a_found_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (status != plt_pkg::ST_DONE))
      |-> (found_handle == 16'd0 && found_start_time == 32'd0))
    else $error("found fields set on a failed operation");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(status)
      && $stable(found_handle) && $stable(found_start_time)
      && $stable(entry_count)))
    else $error("stalled result changed");

endmodule

bind positional_list_table plt_chk u_plt_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .status           (out_ch.status),
  .found_handle     (out_ch.found_handle),
  .found_start_time (out_ch.found_start_time),
  .entry_count      (out_ch.entry_count),
  .is_empty         (out_ch.is_empty)
);

/* dv/tb.sv */
// Testbench for the positional list table: directed and random list traffic checked against a predictor.
`timescale 1ns / 1ps

module tb;

  localparam int CAPACITY = 64;
  // Codes above OP_TAKE are ignored by the block.
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;
  localparam int RANDOM_CMDS = 1600;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 80;

  // Scoreboard: mirrors the list contents and queues one expected result per
  // accepted command, in command order.
  class list_scoreboard;
    logic [15:0]    handles[CAPACITY];
    logic [31:0]    keys[CAPACITY];
    int unsigned    count;
    plt_pkg::rsp_t  expected_q[$];
    int             errors;

    function new();
      count = 0;
      errors = 0;
    endfunction

    // Close the gap left at idx by sliding the tail down.
    function void remove_at(int unsigned idx);
      for (int unsigned i = idx; i + 1 < count; i++) begin
        handles[i] = handles[i + 1];
        keys[i] = keys[i + 1];
      end
      count--;
    endfunction

    function void note_command(plt_pkg::cmd_t c);
      plt_pkg::rsp_t r;
      int unsigned   at;
      int            hit;
      r = '0;
      r.status = plt_pkg::ST_DONE;
      hit = -1;
      case (c.operation)
        plt_pkg::OP_APPEND, plt_pkg::OP_INSERT: begin
          at = (c.operation == plt_pkg::OP_APPEND) ? count : c.position;
          if (count >= CAPACITY) begin
            r.status = plt_pkg::ST_FULL;
          end else if (at > count) begin
            r.status = plt_pkg::ST_RANGE;
          end else begin
            for (int unsigned i = count; i > at; i--) begin
              handles[i] = handles[i - 1];
              keys[i] = keys[i - 1];
            end
            handles[at] = c.entry_handle;
            keys[at] = c.entry_key;
            count++;
          end
        end
        plt_pkg::OP_DELETE, plt_pkg::OP_READ: begin
          if (c.position >= count) begin
            r.status = plt_pkg::ST_RANGE;
          end else begin
            r.found.handle = handles[c.position];
            r.found.entry_key = keys[c.position];
            if (c.operation == plt_pkg::OP_DELETE) remove_at(c.position);
          end
        end
        plt_pkg::OP_TAKE: begin
          // first match from the head wins
          for (int i = 0; i < count; i++) begin
            if (hit < 0 && keys[i] == c.entry_key) hit = i;
          end
          if (hit < 0) begin
            r.status = plt_pkg::ST_NOKEY;
          end else begin
            r.found.handle = handles[hit];
            r.found.entry_key = keys[hit];
            remove_at(hit);
          end
        end
        default: ;
      endcase
      r.entry_count = 7'(count);
      r.is_empty = (count == 0);
      expected_q.push_back(r);
    endfunction

    function void check_result(plt_pkg::rsp_t got);
      plt_pkg::rsp_t exp_rsp;
      if (expected_q.size() == 0) begin
        $error("result with no command outstanding");
        errors++;
        return;
      end
      exp_rsp = expected_q.pop_front();
      if (got.status !== exp_rsp.status) begin
        $error("status: expected %0d, got %0d", exp_rsp.status, got.status);
        errors++;
      end
      if (got.found.handle !== exp_rsp.found.handle) begin
        $error("found_handle: expected %h, got %h",
               exp_rsp.found.handle, got.found.handle);
        errors++;
      end
      if (got.found.entry_key !== exp_rsp.found.entry_key) begin
        $error("found_start_time: expected %h, got %h",
               exp_rsp.found.entry_key, got.found.entry_key);
        errors++;
      end
      if (got.entry_count !== exp_rsp.entry_count) begin
        $error("entry_count: expected %0d, got %0d",
               exp_rsp.entry_count, got.entry_count);
        errors++;
      end
      if (got.is_empty !== exp_rsp.is_empty) begin
        $error("is_empty: expected %0b, got %0b", exp_rsp.is_empty, got.is_empty);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   no_idle = 1'b0;   // set during the stretch where neither side idles

  plt_in_if  in_ch();
  plt_out_if out_ch();

  list_scoreboard sb = new();

  positional_list_table #(.CAPACITY(CAPACITY)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Global watchdog. Its limit covers the work of every command plus sender
  // gaps and result stalls for the whole run, with a wide margin.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  // Result side: random backpressure, check every transfer.
  initial begin
    plt_pkg::rsp_t got;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.status = out_ch.status;
        got.found.handle = out_ch.found_handle;
        got.found.entry_key = out_ch.found_start_time;
        got.entry_count = out_ch.entry_count;
        got.is_empty = out_ch.is_empty;
        sb.check_result(got);
      end
      out_ch.ready <= no_idle || ($urandom_range(0, 99) >= 9);
    end
  end

  function automatic plt_pkg::cmd_t make_cmd(logic [2:0] op, logic [5:0] pos,
                                             logic [15:0] handle, logic [31:0] key);
    plt_pkg::cmd_t c;
    c.operation = op;
    c.position = pos;
    c.entry_handle = handle;
    c.entry_key = key;
    return c;
  endfunction

  // Present one command and hold it until the transfer; the scoreboard learns
  // of it at the accepting edge. Valid stays high into the next command unless
  // an idle gap is taken.
  task automatic send_cmd(plt_pkg::cmd_t c);
    while (!no_idle && $urandom_range(0, 99) < 9) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= c.operation;
    in_ch.position <= c.position;
    in_ch.entry_handle <= c.entry_handle;
    in_ch.entry_key <= c.entry_key;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_command(c);
  endtask

  // Hold off the sender until every outstanding result has come back.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.expected_q.size() != 0);
  endtask

  // Random command biased toward moving the fill level to goal. Keys come
  // often from a small set so duplicates exist, and takes mostly aim at a
  // key that is present.
  function automatic plt_pkg::cmd_t random_cmd(int unsigned goal);
    logic [2:0]  ops[5] = '{plt_pkg::OP_APPEND, plt_pkg::OP_INSERT, plt_pkg::OP_DELETE,
                            plt_pkg::OP_READ, plt_pkg::OP_TAKE};
    logic [31:0] key_set[6] = '{32'h0, 32'hFFFF_FFFF, 32'h1, 32'h8000_0000,
                                32'h5A5A_A5A5, 32'h0000_1000};
    int unsigned cnt;
    int unsigned r;
    logic [2:0]  op;
    logic [5:0]  pos;
    logic [31:0] key;
    cnt = sb.count;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    end else begin
      r = $urandom_range(0, 99);
      if (cnt < goal && r < 65) begin
        op = (r < 40) ? plt_pkg::OP_APPEND : plt_pkg::OP_INSERT;
      end else if (cnt > goal && r < 65) begin
        op = (r < 35) ? plt_pkg::OP_DELETE : plt_pkg::OP_TAKE;
      end else begin
        op = ops[$urandom_range(0, 4)];
      end
    end
    if ($urandom_range(0, 4) != 0) pos = 6'($urandom_range(0, (cnt > 63) ? 63 : cnt));
    else pos = 6'($urandom_range(0, 63));
    r = $urandom_range(0, 99);
    if (op == plt_pkg::OP_TAKE && cnt > 0 && r < 70) begin
      key = sb.keys[$urandom_range(0, cnt - 1)];
    end else if (r < 50) begin
      key = key_set[$urandom_range(0, 5)];
    end else begin
      key = $urandom;
    end
    return make_cmd(op, pos, 16'($urandom), key);
  endfunction

  initial begin
    int unsigned   goal;
    int unsigned   dwell;
    int unsigned   dwell_max;
    int unsigned   issued;
    plt_pkg::cmd_t c;

    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.operation <= plt_pkg::OP_APPEND;
    in_ch.position <= '0;
    in_ch.entry_handle <= '0;
    in_ch.entry_key <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-list corner cases first.
    send_cmd(make_cmd(plt_pkg::OP_READ,   6'd0,  16'h0000, 32'h0));   // read on empty
    send_cmd(make_cmd(plt_pkg::OP_DELETE, 6'd0,  16'h0000, 32'h0));   // pop on empty
    send_cmd(make_cmd(plt_pkg::OP_TAKE,   6'd0,  16'h0000, 32'h0));   // take, no keys
    send_cmd(make_cmd(plt_pkg::OP_INSERT, 6'd1,  16'h1111, 32'h1));   // insert past end
    send_cmd(make_cmd(plt_pkg::OP_INSERT, 6'd0,  16'hFFFF, 32'hFFFF_FFFF)); // all ones
    send_cmd(make_cmd(plt_pkg::OP_APPEND, 6'd63, 16'h0000, 32'h0));   // all zeros
    send_cmd(make_cmd(plt_pkg::OP_INSERT, 6'd2,  16'h1234, 32'h5));   // insert at count
    send_cmd(make_cmd(plt_pkg::OP_INSERT, 6'd1,  16'hA5A5, 32'h5));   // duplicate key
    send_cmd(make_cmd(plt_pkg::OP_READ,   6'd3,  16'h0000, 32'h0));   // last entry
    send_cmd(make_cmd(plt_pkg::OP_READ,   6'd4,  16'h0000, 32'h0));   // position == count
    send_cmd(make_cmd(plt_pkg::OP_READ,   6'd63, 16'h0000, 32'h0));   // far past end
    send_cmd(make_cmd(plt_pkg::OP_TAKE,   6'd0,  16'h0000, 32'h5));   // first match wins
    send_cmd(make_cmd(OP_UNUSED_LO, 6'd0, 16'hBEEF, 32'h5));          // ignored codes
    send_cmd(make_cmd(3'(OP_UNUSED_LO + 1), 6'd2, 16'hBEEF, 32'h0));
    send_cmd(make_cmd(OP_UNUSED_HI, 6'd63, 16'hBEEF, 32'hFFFF_FFFF));
    send_cmd(make_cmd(plt_pkg::OP_DELETE, 6'd0,  16'h0000, 32'h0));   // pop
    send_cmd(make_cmd(plt_pkg::OP_TAKE,   6'd0,  16'h0000, 32'hDEAD_BEEF)); // key absent
    send_cmd(make_cmd(plt_pkg::OP_DELETE, 6'd1,  16'h0000, 32'h0));   // delete last
    send_cmd(make_cmd(plt_pkg::OP_DELETE, 6'd0,  16'h0000, 32'h0));   // back to empty

    // Sender holds off until the block has answered everything.
    drain_results();

    // Random part: walk the fill level between empty, full and points in
    // between, lingering at each goal so full and range cases get hit.
    goal = CAPACITY;
    dwell = 0;
    dwell_max = 12;
    issued = 0;
    while (issued < RANDOM_CMDS) begin
      no_idle = (issued >= 600 && issued < 900);
      c = random_cmd(goal);
      send_cmd(c);
      if (c.operation <= plt_pkg::OP_TAKE) issued++;
      if (sb.count == goal) dwell++;
      if (dwell > dwell_max) begin
        case ($urandom_range(0, 3))
          0:       goal = 0;
          1:       goal = CAPACITY;
          default: goal = $urandom_range(1, CAPACITY - 1);
        endcase
        dwell = 0;
        dwell_max = $urandom_range(4, 20);
        if ($urandom_range(0, 3) == 0) drain_results();
      end
    end
    no_idle = 1'b0;

    // Wind down: wait for the last results, then let the block sit a while
    // so a stray extra result would still be caught.
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/plt_pkg.sv
sv/plt_ifs.sv
sv/plt_ram.sv
sv/plt_ctrl.sv
sv/positional_list_table.sv
sv/plt_chk.sv
dv/tb.sv
